// ===== hw/rtl/random_segment_waveform_generator_unit_defines.svh =====
// assertion macros shared by the random segment waveform generator rtl
`ifndef RANDOM_SEGMENT_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define RANDOM_SEGMENT_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RSWG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define RSWG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define RSWG_ASSERT(name, prop, msg)

`define RSWG_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ===== hw/rtl/rswg_pkg.sv =====
// shared types and constants of the random segment waveform generator
`default_nettype none

package rswg_pkg;

  parameter int unsigned SLOPE_W    = 34;
  parameter int unsigned DIVIDEND_W = 32;
  parameter int unsigned DIV_CNT_W  = 5;
  parameter logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  parameter int unsigned CFG_ADDR_W = 4;
  parameter int unsigned CFG_DATA_W = 32;

  parameter logic [15:0] GAIN_RESET = 16'd328;
  parameter logic [31:0] MIN_RESET  = 32'd6000;
  parameter logic [31:0] MAX_RESET  = 32'd12000;

  typedef enum logic [1:0] {
    REG_GAIN       = 2'd0,
    REG_MIN_LENGTH = 2'd1,
    REG_MAX_LENGTH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LEVEL,
    ST_SCALE,
    ST_SPAN,
    ST_SEG,
    ST_DIV,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic load_item;
    logic mul;
    logic level;
    logic scale;
    logic span;
    logic seg_start;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic seg_end;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rswg_if.sv =====
// request and result channel interfaces
`default_nettype none

interface rswg_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        rand_length;
  logic signed [15:0] rand_level;

  modport source (output valid, output rand_length, output rand_level, input ready);
  modport sink (input valid, input rand_length, input rand_level, output ready);
endinterface

interface rswg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               segment_end;

  modport source (output valid, output sample, output segment_end, input ready);
  modport sink (input valid, input sample, input segment_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/random_segment_waveform_generator_unit.sv =====
// top level of the random segment waveform generator
// Each request yields one result: the gain-scaled level at the current
// position of a straight segment, and a flag set when that request closed
// the segment. A result reaches the output register via the MUL, LEVEL,
// SCALE and PUSH states, and the next request can be taken in the cycle
// after that push; one that ends a segment also passes SPAN, SEG and DIV
// as the new slope comes from a 32-step restoring divider with one quotient
// bit a cycle. A result waiting in the output register does not block the
// next request, only the push of its result. Registers sit on the apb port
// at byte offsets 0 (gain), 4 (min length) and 8 (max length).
`default_nettype none

module random_segment_waveform_generator_unit #(
  parameter int unsigned LENGTH_BITS = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rswg_in_if.sink                         in_if,
  rswg_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rswg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rswg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rswg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [15:0]            gain;
  logic [LENGTH_BITS-1:0] min_length;
  logic [LENGTH_BITS-1:0] max_length;
  rswg_pkg::cmd_t         cmd;
  rswg_pkg::sts_t         sts;

  rswg_cfg #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .gain_o       (gain),
    .min_length_o (min_length),
    .max_length_o (max_length)
  );

  rswg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rswg_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .gain_i        (gain),
    .min_length_i  (min_length),
    .max_length_i  (max_length),
    .rand_length_i (in_if.rand_length),
    .rand_level_i  (in_if.rand_level),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .sample_o      (out_if.sample),
    .segment_end_o (out_if.segment_end)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rswg_cfg.sv =====
// apb configuration registers
`default_nettype none

module rswg_cfg #(
  parameter int unsigned LENGTH_BITS = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rswg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rswg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rswg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [15:0]                         gain_o,
  output logic [LENGTH_BITS-1:0]              min_length_o,
  output logic [LENGTH_BITS-1:0]              max_length_o
);

  logic                   wr_en;
  rswg_pkg::reg_idx_e     reg_idx;
  logic [15:0]            gain_q;
  logic [LENGTH_BITS-1:0] min_q;
  logic [LENGTH_BITS-1:0] max_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = rswg_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= rswg_pkg::GAIN_RESET;
      min_q  <= rswg_pkg::MIN_RESET[LENGTH_BITS-1:0];
      max_q  <= rswg_pkg::MAX_RESET[LENGTH_BITS-1:0];
    end else if (wr_en) begin
      case (reg_idx)
        rswg_pkg::REG_GAIN:       gain_q <= pwdata[15:0];
        rswg_pkg::REG_MIN_LENGTH: min_q  <= pwdata[LENGTH_BITS-1:0];
        rswg_pkg::REG_MAX_LENGTH: max_q  <= pwdata[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rswg_pkg::REG_GAIN:       prdata = rswg_pkg::CFG_DATA_W'(gain_q);
      rswg_pkg::REG_MIN_LENGTH: prdata = rswg_pkg::CFG_DATA_W'(min_q);
      rswg_pkg::REG_MAX_LENGTH: prdata = rswg_pkg::CFG_DATA_W'(max_q);
      default:                  prdata = '0;
    endcase
  end

  assign gain_o       = gain_q;
  assign min_length_o = min_q;
  assign max_length_o = max_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rswg_ctrl.sv =====
// sequencing state machine
`default_nettype none
`include "random_segment_waveform_generator_unit_defines.svh"

module rswg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rswg_pkg::sts_t sts_i,
  output rswg_pkg::cmd_t cmd_o
);

  rswg_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rswg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rswg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = rswg_pkg::ST_MUL;
        end
      end
      rswg_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = rswg_pkg::ST_LEVEL;
      end
      rswg_pkg::ST_LEVEL: begin
        cmd_o.level = 1'b1;
        state_d     = rswg_pkg::ST_SCALE;
      end
      rswg_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = sts_i.seg_end ? rswg_pkg::ST_SPAN : rswg_pkg::ST_PUSH;
      end
      rswg_pkg::ST_SPAN: begin
        cmd_o.span = 1'b1;
        state_d    = rswg_pkg::ST_SEG;
      end
      rswg_pkg::ST_SEG: begin
        cmd_o.seg_start = 1'b1;
        state_d         = rswg_pkg::ST_DIV;
      end
      rswg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = rswg_pkg::ST_PUSH;
        end
      end
      rswg_pkg::ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = rswg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rswg_pkg::ST_IDLE;
      end
    endcase
  end

  `RSWG_ASSERT(a_push_needs_slot, cmd_o.push |-> sts_i.out_free, "result pushed into full slot")
  `RSWG_ASSERT(a_span_on_end, (state_q == rswg_pkg::ST_SPAN) |-> sts_i.seg_end, "new segment without end")
  `RSWG_ASSERT(a_div_exit, (state_q == rswg_pkg::ST_DIV && sts_i.div_done) |=> (state_q == rswg_pkg::ST_PUSH), "divider exit missed")

endmodule

`default_nettype wire

// ===== hw/rtl/rswg_dp.sv =====
// interpolation, scaling, segment draw and slope divider
`default_nettype none
`include "random_segment_waveform_generator_unit_defines.svh"

module rswg_dp #(
  parameter int unsigned LENGTH_BITS = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rswg_pkg::cmd_t         cmd_i,
  output rswg_pkg::sts_t         sts_o,
  input  logic [15:0]            gain_i,
  input  logic [LENGTH_BITS-1:0] min_length_i,
  input  logic [LENGTH_BITS-1:0] max_length_i,
  input  logic [15:0]            rand_length_i,
  input  logic signed [15:0]     rand_level_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [15:0]     sample_o,
  output logic                   segment_end_o
);

  localparam int unsigned PROD_W      = rswg_pkg::SLOPE_W + LENGTH_BITS + 1;
  localparam int unsigned SUM_W       = PROD_W - 15;
  localparam int unsigned SPAN_PROD_W = LENGTH_BITS + 17;
  localparam int unsigned DW          = rswg_pkg::DIVIDEND_W;
  localparam logic signed [SUM_W-1:0] LVL_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] LVL_MIN = SUM_W'(-32768);
  localparam logic signed [17:0]      SMP_MAX = 18'sd32767;
  localparam logic signed [17:0]      SMP_MIN = -18'sd32768;

  // segment state
  logic [LENGTH_BITS-1:0]              pos_q;
  logic [LENGTH_BITS-1:0]              len_q;
  logic signed [15:0]                  start_q;
  logic signed [15:0]                  target_q;
  logic signed [rswg_pkg::SLOPE_W-1:0] slope_q;

  // per item working registers
  logic [15:0]                  rlen_q;
  logic signed [15:0]           rlev_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic                         seg_end_q;
  logic signed [15:0]           level_q;
  logic signed [15:0]           smp_q;
  logic [SPAN_PROD_W-1:0]       span_prod_q;
  logic [LENGTH_BITS-1:0]       rem_q;
  logic [DW-1:0]                quo_q;
  logic [rswg_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                         neg_q;

  // output slot
  logic                         out_valid_q;
  logic signed [15:0]           out_sample_q;
  logic                         out_end_q;

  logic signed [PROD_W-1:0]     prod_d;
  logic [LENGTH_BITS-1:0]       pos_inc;
  logic                         end_d;
  logic signed [SUM_W-1:0]      lvl_sum;
  logic signed [15:0]           level_d;
  logic signed [32:0]           gprod;
  logic signed [17:0]           gsh;
  logic signed [15:0]           smp_d;
  logic [LENGTH_BITS-1:0]       lo_eff;
  logic [LENGTH_BITS:0]         span;
  logic [LENGTH_BITS:0]         len_sum;
  logic [LENGTH_BITS-1:0]       len_new;
  logic signed [16:0]           diff;
  logic [16:0]                  neg_diff;
  logic [15:0]                  mag;
  logic [LENGTH_BITS:0]         shl;
  logic [LENGTH_BITS:0]         trial;
  logic                         ge;
  logic [rswg_pkg::SLOPE_W-1:0] quo_ext;

  assign prod_d  = PROD_W'(slope_q) * PROD_W'($signed({1'b0, pos_q}));
  assign pos_inc = pos_q + 1'b1;
  assign end_d   = (pos_inc >= len_q) || (pos_inc == '0);

  assign lvl_sum = SUM_W'($signed(prod_q[PROD_W-1:16])) + SUM_W'(start_q);

  always_comb begin
    if (lvl_sum > LVL_MAX) begin
      level_d = 16'sh7fff;
    end else if (lvl_sum < LVL_MIN) begin
      level_d = -16'sh8000;
    end else begin
      level_d = lvl_sum[15:0];
    end
  end

  assign gprod = 33'($signed({1'b0, gain_i})) * 33'(level_q);
  assign gsh   = $signed(gprod[32:15]);

  always_comb begin
    if (gsh > SMP_MAX) begin
      smp_d = 16'sh7fff;
    end else if (gsh < SMP_MIN) begin
      smp_d = -16'sh8000;
    end else begin
      smp_d = gsh[15:0];
    end
  end

  assign lo_eff  = (min_length_i == '0) ? LENGTH_BITS'(1) : min_length_i;
  assign span    = {1'b0, max_length_i} - {1'b0, lo_eff} + 1'b1;
  assign len_sum = (max_length_i <= lo_eff) ? {1'b0, lo_eff}
                 : {1'b0, lo_eff} + {1'b0, span_prod_q[LENGTH_BITS+15:16]};
  assign len_new = (len_sum[LENGTH_BITS-1:0] == '0) ? LENGTH_BITS'(1)
                 : len_sum[LENGTH_BITS-1:0];

  assign diff     = {rlev_q[15], rlev_q} - {target_q[15], target_q};
  assign neg_diff = -diff;
  assign mag      = diff[16] ? neg_diff[15:0] : diff[15:0];

  // restoring divider, one quotient bit a cycle
  assign shl   = {rem_q, quo_q[DW-1]};
  assign trial = shl - {1'b0, len_q};
  assign ge    = !trial[LENGTH_BITS];

  assign quo_ext = rswg_pkg::SLOPE_W'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= LENGTH_BITS'(1);
      start_q  <= '0;
      target_q <= '0;
      slope_q  <= '0;
    end else begin
      if (cmd_i.mul) begin
        pos_q <= end_d ? '0 : pos_inc;
      end
      if (cmd_i.seg_start) begin
        len_q    <= len_new;
        start_q  <= target_q;
        target_q <= rlev_q;
      end
      if (cmd_i.push && seg_end_q) begin
        slope_q <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      rlen_q <= rand_length_i;
      rlev_q <= rand_level_i;
    end
    if (cmd_i.mul) begin
      prod_q    <= prod_d;
      seg_end_q <= end_d;
    end
    if (cmd_i.level) begin
      level_q <= level_d;
    end
    if (cmd_i.scale) begin
      smp_q <= smp_d;
    end
    if (cmd_i.span) begin
      span_prod_q <= SPAN_PROD_W'(rlen_q) * SPAN_PROD_W'(span);
    end
    if (cmd_i.seg_start) begin
      rem_q <= '0;
      quo_q <= {mag, 16'd0};
      neg_q <= diff[16];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial[LENGTH_BITS-1:0] : shl[LENGTH_BITS-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.push) begin
      out_sample_q <= smp_q;
      out_end_q    <= seg_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.seg_end  = seg_end_q;
  assign sts_o.div_done = (cnt_q == rswg_pkg::DIV_LAST);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sample_o      = out_sample_q;
  assign segment_end_o = out_end_q;

  `RSWG_ASSERT_NEVER(a_len_zero, len_q == '0, "segment length is zero")
  `RSWG_ASSERT(a_pos_in_seg, pos_q < len_q, "position beyond segment length")

endmodule

`default_nettype wire
